// ===== sv/urgb_pkg.sv =====
package urgb_pkg;

  localparam int COEF_FRAC_BITS_DEF = 16;

  localparam longint DEC_SCALE = 64'd10000000;

  localparam longint DEC_R_U = 64'd9267;
  localparam longint DEC_R_V = 64'd14016868;
  localparam longint DEC_G_U = 64'd3436954;
  localparam longint DEC_G_V = 64'd7141690;
  localparam longint DEC_B_U = 64'd17721604;
  localparam longint DEC_B_V = 64'd9902;

  localparam logic [8:0] CHROMA_MID = 9'd128;
  localparam logic [7:0] PIX_MAX    = 8'd255;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // round to nearest, ties away from zero, at elaboration only
  function automatic longint fix_coef(input longint dec, input int frac);
    return ((dec << frac) + DEC_SCALE / 2) / DEC_SCALE;
  endfunction

endpackage

// ===== sv/urgb_mul.sv =====
module urgb_mul import urgb_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int PW             = COEF_FRAC_BITS + 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           chroma_u,
  input  logic [7:0]           luma_first,
  input  logic [7:0]           chroma_v,
  input  logic [7:0]           luma_second,
  input  logic                 last_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [PW-1:0] prod_ru,
  output logic signed [PW-1:0] prod_rv,
  output logic signed [PW-1:0] prod_gu,
  output logic signed [PW-1:0] prod_gv,
  output logic signed [PW-1:0] prod_bu,
  output logic signed [PW-1:0] prod_bv,
  output logic [7:0]           luma_first_o,
  output logic [7:0]           luma_second_o,
  output logic                 last_o
);

  localparam int CW = COEF_FRAC_BITS + 2;

  localparam logic [CW-1:0] K_R_U = CW'(fix_coef(DEC_R_U, COEF_FRAC_BITS));
  localparam logic [CW-1:0] K_R_V = CW'(fix_coef(DEC_R_V, COEF_FRAC_BITS));
  localparam logic [CW-1:0] K_G_U = CW'(fix_coef(DEC_G_U, COEF_FRAC_BITS));
  localparam logic [CW-1:0] K_G_V = CW'(fix_coef(DEC_G_V, COEF_FRAC_BITS));
  localparam logic [CW-1:0] K_B_U = CW'(fix_coef(DEC_B_U, COEF_FRAC_BITS));
  localparam logic [CW-1:0] K_B_V = CW'(fix_coef(DEC_B_V, COEF_FRAC_BITS));

  logic signed [CW:0]   kru_s, krv_s, kgu_s, kgv_s, kbu_s, kbv_s;
  logic signed [8:0]    du, dv;
  logic                 valid_r;
  logic signed [PW-1:0] p_ru_r, p_rv_r, p_gu_r, p_gv_r, p_bu_r, p_bv_r;
  logic signed [PW-1:0] p_ru_nxt, p_rv_nxt, p_gu_nxt, p_gv_nxt, p_bu_nxt, p_bv_nxt;
  logic [7:0]           y1_r, y2_r;
  logic                 last_r;

  assign kru_s = {1'b0, K_R_U};
  assign krv_s = {1'b0, K_R_V};
  assign kgu_s = {1'b0, K_G_U};
  assign kgv_s = {1'b0, K_G_V};
  assign kbu_s = {1'b0, K_B_U};
  assign kbv_s = {1'b0, K_B_V};

  assign du = signed'({1'b0, chroma_u} - CHROMA_MID);
  assign dv = signed'({1'b0, chroma_v} - CHROMA_MID);

  assign p_ru_nxt = PW'(kru_s) * PW'(du);
  assign p_rv_nxt = PW'(krv_s) * PW'(dv);
  assign p_gu_nxt = PW'(kgu_s) * PW'(du);
  assign p_gv_nxt = PW'(kgv_s) * PW'(dv);
  assign p_bu_nxt = PW'(kbu_s) * PW'(du);
  assign p_bv_nxt = PW'(kbv_s) * PW'(dv);

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_ru_r <= p_ru_nxt;
      p_rv_r <= p_rv_nxt;
      p_gu_r <= p_gu_nxt;
      p_gv_r <= p_gv_nxt;
      p_bu_r <= p_bu_nxt;
      p_bv_r <= p_bv_nxt;
      y1_r   <= luma_first;
      y2_r   <= luma_second;
      last_r <= last_in;
    end
  end

  assign out_valid     = valid_r;
  assign prod_ru       = p_ru_r;
  assign prod_rv       = p_rv_r;
  assign prod_gu       = p_gu_r;
  assign prod_gv       = p_gv_r;
  assign prod_bu       = p_bu_r;
  assign prod_bv       = p_bv_r;
  assign luma_first_o  = y1_r;
  assign luma_second_o = y2_r;
  assign last_o        = last_r;

endmodule

// ===== sv/urgb_acc.sv =====
module urgb_acc import urgb_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int PW             = COEF_FRAC_BITS + 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [PW-1:0] prod_ru,
  input  logic signed [PW-1:0] prod_rv,
  input  logic signed [PW-1:0] prod_gu,
  input  logic signed [PW-1:0] prod_gv,
  input  logic signed [PW-1:0] prod_bu,
  input  logic signed [PW-1:0] prod_bv,
  input  logic [7:0]           luma_first,
  input  logic [7:0]           luma_second,
  input  logic                 last_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [PW-1:0] sum_r1,
  output logic signed [PW-1:0] sum_g1,
  output logic signed [PW-1:0] sum_b1,
  output logic signed [PW-1:0] sum_r2,
  output logic signed [PW-1:0] sum_g2,
  output logic signed [PW-1:0] sum_b2,
  output logic                 last_o
);

  logic signed [PW-1:0] y1_s, y2_s, w_r, w_g, w_b;
  logic signed [PW-1:0] r1_nxt, g1_nxt, b1_nxt, r2_nxt, g2_nxt, b2_nxt;
  logic signed [PW-1:0] r1_r, g1_r, b1_r, r2_r, g2_r, b2_r;
  logic                 valid_r, last_r;

  assign y1_s = signed'(PW'(luma_first)  << COEF_FRAC_BITS);
  assign y2_s = signed'(PW'(luma_second) << COEF_FRAC_BITS);

  assign w_r = prod_rv - prod_ru;
  assign w_g = -prod_gu - prod_gv;
  assign w_b = prod_bu + prod_bv;

  assign r1_nxt = y1_s + w_r;
  assign g1_nxt = y1_s + w_g;
  assign b1_nxt = y1_s + w_b;
  assign r2_nxt = y2_s + w_r;
  assign g2_nxt = y2_s + w_g;
  assign b2_nxt = y2_s + w_b;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r1_r   <= r1_nxt;
      g1_r   <= g1_nxt;
      b1_r   <= b1_nxt;
      r2_r   <= r2_nxt;
      g2_r   <= g2_nxt;
      b2_r   <= b2_nxt;
      last_r <= last_in;
    end
  end

  assign out_valid = valid_r;
  assign sum_r1    = r1_r;
  assign sum_g1    = g1_r;
  assign sum_b1    = b1_r;
  assign sum_r2    = r2_r;
  assign sum_g2    = g2_r;
  assign sum_b2    = b2_r;
  assign last_o    = last_r;

endmodule

// ===== sv/urgb_sat.sv =====
module urgb_sat import urgb_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int PW             = COEF_FRAC_BITS + 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [PW-1:0]  sum_r1,
  input  logic signed [PW-1:0]  sum_g1,
  input  logic signed [PW-1:0]  sum_b1,
  input  logic signed [PW-1:0]  sum_r2,
  input  logic signed [PW-1:0]  sum_g2,
  input  logic signed [PW-1:0]  sum_b2,
  input  logic                  last_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] pix_data,
  output logic                  last_o
);

  localparam int IW = PW - COEF_FRAC_BITS;

  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  valid_r, last_r;

  // floor by arithmetic shift, then clamp to 0..255
  function automatic logic [7:0] clamp(input logic signed [PW-1:0] s);
    logic [IW-1:0] whole;
    whole = s[PW-1:COEF_FRAC_BITS];
    if (whole[IW-1]) begin
      return 8'd0;
    end else if (|whole[IW-2:8]) begin
      return PIX_MAX;
    end else begin
      return whole[7:0];
    end
  endfunction

  assign data_nxt = {clamp(sum_b2), clamp(sum_g2), clamp(sum_r2),
                     clamp(sum_b1), clamp(sum_g1), clamp(sum_r1)};

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
      last_r <= last_in;
    end
  end

  assign out_valid = valid_r;
  assign pix_data  = data_r;
  assign last_o    = last_r;

endmodule

// ===== sv/uyvy_to_rgb24_converter.sv =====
// UYVY 4:2:2 to RGB24 colour converter.
// Slave channel in_*: one UYVY macropixel per transaction, in_tdata carries
// U, Y0, V, Y1 from the lowest byte up; in_tlast marks the final macropixel.
// Master channel out_*: one transaction per macropixel with two RGB pixels,
// out_tdata carries R0, G0, B0, R1, G1, B1 from the lowest byte up; out_tlast
// repeats in_tlast of the same macropixel.
// Three register stages lie between input and output transaction: a multiplier
// stage (six chroma products shared by both pixels), an adder stage (luma
// plus weighted chroma) and a floor/clamp stage that is the output register.
// Throughput is one macropixel per cycle while out_tready is high; each stage holds one transaction.
// Reset clears every stage valid bit; no result is pending afterwards.
// When the receiver stalls, each stage holds its transaction while full and
// in_tready falls once all three stages are full; empty stages keep filling.
// COEF_FRAC_BITS sets the fractional precision of the colour coefficients.
module uyvy_to_rgb24_converter import urgb_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // chroma_u, luma_first, chroma_v, luma_second
  input  logic                  in_tlast,   // last_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // red_first, green_first, blue_first,
                                            // red_second, green_second, blue_second
  output logic                  out_tlast   // last_out
);

  localparam int PW = COEF_FRAC_BITS + 12;

  logic                 mul_valid, mul_ready, acc_valid, acc_ready;
  logic signed [PW-1:0] p_ru, p_rv, p_gu, p_gv, p_bu, p_bv;
  logic signed [PW-1:0] s_r1, s_g1, s_b1, s_r2, s_g2, s_b2;
  logic [7:0]           mul_y1, mul_y2;
  logic                 mul_last, acc_last;

  urgb_mul #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .PW(PW)) u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .chroma_u     (in_tdata[7:0]),
    .luma_first   (in_tdata[15:8]),
    .chroma_v     (in_tdata[23:16]),
    .luma_second  (in_tdata[31:24]),
    .last_in      (in_tlast),
    .out_valid    (mul_valid),
    .out_ready    (mul_ready),
    .prod_ru      (p_ru),
    .prod_rv      (p_rv),
    .prod_gu      (p_gu),
    .prod_gv      (p_gv),
    .prod_bu      (p_bu),
    .prod_bv      (p_bv),
    .luma_first_o (mul_y1),
    .luma_second_o(mul_y2),
    .last_o       (mul_last)
  );

  urgb_acc #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .PW(PW)) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mul_valid),
    .in_ready   (mul_ready),
    .prod_ru    (p_ru),
    .prod_rv    (p_rv),
    .prod_gu    (p_gu),
    .prod_gv    (p_gv),
    .prod_bu    (p_bu),
    .prod_bv    (p_bv),
    .luma_first (mul_y1),
    .luma_second(mul_y2),
    .last_in    (mul_last),
    .out_valid  (acc_valid),
    .out_ready  (acc_ready),
    .sum_r1     (s_r1),
    .sum_g1     (s_g1),
    .sum_b1     (s_b1),
    .sum_r2     (s_r2),
    .sum_g2     (s_g2),
    .sum_b2     (s_b2),
    .last_o     (acc_last)
  );

  urgb_sat #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .PW(PW)) u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (acc_valid),
    .in_ready (acc_ready),
    .sum_r1   (s_r1),
    .sum_g1   (s_g1),
    .sum_b1   (s_b1),
    .sum_r2   (s_r2),
    .sum_g2   (s_g2),
    .sum_b2   (s_b2),
    .last_in  (acc_last),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .pix_data (out_tdata),
    .last_o   (out_tlast)
  );

endmodule

// ===== sv/urgb_checker.sv =====
module urgb_checker import urgb_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while receiver ready");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind uyvy_to_rgb24_converter urgb_checker u_urgb_checker (.*);
